// ===== hdl/apq_pkg.sv =====
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants of the aging priority request queue
// Field widths, status codes, the priority type and the saturating age step.
// ----------------------------------------------------------------------------
package apq_pkg;

  // default queue depth, one entry per requester
  localparam int NUM_REQUESTERS_DEF = 6;
  localparam int NUM_BASE_REGS      = 6;

  // port field widths
  localparam int ID_W     = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int BASE_W   = 3;
  localparam int PRIO_W   = 8;

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [ID_W-1:0]          id_t;
  typedef logic [BASE_W-1:0]        base_t;
  typedef logic [STATUS_W-1:0]      status_t;

  // priority limit for the search, and the aging floor
  localparam prio_t AGING_LIMIT = prio_t'(7);
  localparam prio_t PRIO_FLOOR  = prio_t'(-128);
  // base priority of a requester without a base register
  localparam base_t BASE_NONE   = base_t'(7);

  // status codes
  localparam status_t ST_ENQUEUED = status_t'(0);
  localparam status_t ST_GRANTED  = status_t'(1);
  localparam status_t ST_EMPTY    = status_t'(2);
  localparam status_t ST_FULL     = status_t'(3);
  localparam status_t ST_DUP      = status_t'(4);

  // mode codes
  localparam logic MODE_ENQ   = 1'b0;
  localparam logic MODE_SERVE = 1'b1;

  // per-cell control, broadcast from the top level
  typedef struct packed {
    logic load;   // take the new requester
    logic serve;  // shift past the winner and age
  } cell_ctl_t;

  // best candidate handed along the cell row
  typedef struct packed {
    prio_t prio;
    id_t   id;
  } best_t;

  // reset values of the base priority registers
  function automatic base_t base_reset(input int idx);
    base_t val;
    case (idx)
      0, 1:    val = base_t'(1);
      2, 3:    val = base_t'(4);
      default: val = base_t'(7);
    endcase
    return val;
  endfunction

  // one aging step, saturating at the floor
  function automatic prio_t age_step(input prio_t p);
    prio_t r;
    if (p == PRIO_FLOOR) r = p;
    else                 r = p - prio_t'(1);
    return r;
  endfunction

endpackage

// ===== hdl/apq_req_if.sv =====
// ----------------------------------------------------------------------------
// apq_req_if: request channel
// Carries one queue operation per item: enqueue a requester or serve a grant.
// ----------------------------------------------------------------------------
interface apq_req_if;
  logic            valid;
  logic            ready;
  logic            mode;
  apq_pkg::id_t    requester_id;

  modport source (output valid, output mode, output requester_id, input ready);
  modport sink   (input valid, input mode, input requester_id, output ready);
endinterface

// ===== hdl/apq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// apq_rsp_if: response channel
// One result item per request: status, granted id and queue fill.
// ----------------------------------------------------------------------------
interface apq_rsp_if;
  logic                         valid;
  logic                         ready;
  apq_pkg::status_t             status;
  apq_pkg::id_t                 granted_id;
  logic [apq_pkg::COUNT_W-1:0]  queue_count;

  modport source (output valid, output status, output granted_id,
                  output queue_count, input ready);
  modport sink   (input valid, input status, input granted_id,
                  input queue_count, output ready);
endinterface

// ===== hdl/apq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// apq_cfg_if: configuration write channel
// Register index and write data for the base priority registers.
// ----------------------------------------------------------------------------
interface apq_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [apq_pkg::CFG_IDX_W-1:0] index;
  apq_pkg::base_t                wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== hdl/apq_cell.sv =====
// ----------------------------------------------------------------------------
// apq_cell: one queue slot
// Holds a requester id and its current priority, takes part in the winner
// search chain and shifts in its right neighbor on a grant at or before it.
// ----------------------------------------------------------------------------
module apq_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 3
) (
  input  logic               clk,
  input  apq_pkg::cell_ctl_t ctl,
  input  logic               valid,
  // new entry
  input  apq_pkg::id_t       load_id,
  input  apq_pkg::prio_t     load_prio,
  // right neighbor contents
  input  apq_pkg::id_t       nxt_id,
  input  apq_pkg::prio_t     nxt_prio,
  // duplicate check
  input  apq_pkg::id_t       match_id,
  output logic               match,
  // search chain
  input  apq_pkg::best_t     best_in,
  input  logic [IDX_W-1:0]   best_idx_in,
  output apq_pkg::best_t     best_out,
  output logic [IDX_W-1:0]   best_idx_out,
  input  logic [IDX_W-1:0]   win_idx,
  // contents, seen by the left neighbor
  output apq_pkg::id_t       id,
  output apq_pkg::prio_t     prio
);

  logic           beats;
  logic           shift;
  apq_pkg::id_t   src_id;
  apq_pkg::prio_t src_prio;

  // duplicate check and search step; strict compare keeps earliest on ties
  always_comb begin
    match = valid && (id == match_id);
    beats = valid && (prio < best_in.prio);
    if (beats) begin
      best_out.prio = prio;
      best_out.id   = id;
      best_idx_out  = IDX_W'(INDEX);
    end else begin
      best_out      = best_in;
      best_idx_out  = best_idx_in;
    end
  end

  // slots at or after the winner close the gap
  always_comb begin
    shift    = (win_idx <= IDX_W'(INDEX));
    src_id   = shift ? nxt_id : id;
    src_prio = shift ? nxt_prio : prio;
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id   <= load_id;
      prio <= load_prio;
    end else if (ctl.serve) begin
      id   <= src_id;
      prio <= apq_pkg::age_step(src_prio);
    end
  end

endmodule

// ===== hdl/aging_priority_request_queue_unit.sv =====
// ----------------------------------------------------------------------------
// aging_priority_request_queue_unit: aging priority request queue
// Arrival-ordered queue of requesters in a row of cells; a serve grants the
// lowest priority below the limit, earliest on ties, else the head, and ages
// the rest.
//
//   channel | dir | fields                                 | item
//   req     | in  | mode, requester_id                     | one operation
//   rsp     | out | status, granted_id, queue_count        | one result
//   cfg     | in  | index, wdata                           | one register write
//
// An item is accepted into the request register, executed once rsp is free
// or being taken, and its result is then registered onto rsp.
// Items flow one per cycle while rsp is taken; the winner search ripples
// through the cell row inside the execute cycle.
// A result not taken stalls execution; one more item may wait in the request register.
// Reset empties the queue and loads the base registers with their defaults;
// slots need no clearing.
// cfg.ready is always high.
// ----------------------------------------------------------------------------
module aging_priority_request_queue_unit #(
  parameter int NUM_REQUESTERS = apq_pkg::NUM_REQUESTERS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  apq_req_if.sink  req,
  apq_rsp_if.source rsp,
  apq_cfg_if.sink  cfg
);

  localparam int CNT_W = $clog2(NUM_REQUESTERS + 1);
  localparam int IDX_W = $clog2(NUM_REQUESTERS);

  // registers
  logic                 busy;
  logic                 req_mode;
  apq_pkg::id_t         req_id;
  logic [CNT_W-1:0]     count;
  apq_pkg::base_t       base_prio [apq_pkg::NUM_BASE_REGS];

  // execute cycle logic
  logic                 exec_fire;
  logic                 full;
  logic                 id_bad;
  logic                 dup;
  logic                 enq_ok;
  logic                 serve_ok;
  logic [CNT_W-1:0]     count_next;
  apq_pkg::status_t     status_next;
  apq_pkg::id_t         gid_next;
  apq_pkg::base_t       load_base;
  apq_pkg::prio_t       load_prio;
  apq_pkg::cell_ctl_t   ctl [NUM_REQUESTERS];

  // cell row wiring
  apq_pkg::id_t         cid   [NUM_REQUESTERS];
  apq_pkg::prio_t       cprio [NUM_REQUESTERS];
  logic [NUM_REQUESTERS-1:0] match;
  apq_pkg::best_t       best     [NUM_REQUESTERS+1];
  logic [IDX_W-1:0]     best_idx [NUM_REQUESTERS+1];

  // handshake
  assign exec_fire = busy && (!rsp.valid || rsp.ready);
  assign req.ready = !busy || exec_fire;
  assign cfg.ready = 1'b1;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.valid && req.ready) begin
      busy <= 1'b1;
    end else if (exec_fire) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_mode <= req.mode;
      req_id   <= req.requester_id;
    end
  end

  // base priority registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < apq_pkg::NUM_BASE_REGS; i++) begin
        base_prio[i] <= apq_pkg::base_reset(i);
      end
    end else if (cfg.valid && (32'(cfg.index) < apq_pkg::NUM_BASE_REGS)) begin
      base_prio[cfg.index] <= cfg.wdata;
    end
  end

  // decode of the pending item
  always_comb begin
    full     = (count == CNT_W'(NUM_REQUESTERS));
    id_bad   = (32'(req_id) >= NUM_REQUESTERS);
    dup      = |match;
    enq_ok   = exec_fire && (req_mode == apq_pkg::MODE_ENQ) && !full && !id_bad && !dup;
    serve_ok = exec_fire && (req_mode == apq_pkg::MODE_SERVE) && (count != '0);

    if (32'(req_id) < apq_pkg::NUM_BASE_REGS) load_base = base_prio[req_id];
    else                                      load_base = apq_pkg::BASE_NONE;
    load_prio = apq_pkg::prio_t'({1'b0, load_base});

    count_next  = count;
    gid_next    = '0;
    status_next = apq_pkg::ST_ENQUEUED;
    if (req_mode == apq_pkg::MODE_ENQ) begin
      if (full || id_bad) begin
        status_next = apq_pkg::ST_FULL;
      end else if (dup) begin
        status_next = apq_pkg::ST_DUP;
      end else begin
        status_next = apq_pkg::ST_ENQUEUED;
        count_next  = count + CNT_W'(1);
      end
    end else if (count == '0) begin
      status_next = apq_pkg::ST_EMPTY;
    end else begin
      status_next = apq_pkg::ST_GRANTED;
      gid_next    = best[NUM_REQUESTERS].id;
      count_next  = count - CNT_W'(1);
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (exec_fire) begin
      count <= count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp.status      <= status_next;
      rsp.granted_id  <= gid_next;
      rsp.queue_count <= apq_pkg::COUNT_W'(count_next);
    end
  end

  // search chain start: nothing below the limit selects the head
  assign best[0].prio = apq_pkg::AGING_LIMIT;
  assign best[0].id   = cid[0];
  assign best_idx[0]  = '0;

  // cell row
  for (genvar i = 0; i < NUM_REQUESTERS; i++) begin : g_cell
    apq_pkg::id_t   nid;
    apq_pkg::prio_t nprio;

    always_comb begin
      ctl[i].load  = enq_ok && (count == CNT_W'(i));
      ctl[i].serve = serve_ok;
    end

    if (i == NUM_REQUESTERS - 1) begin : g_last
      assign nid   = cid[i];
      assign nprio = cprio[i];
    end else begin : g_mid
      assign nid   = cid[i+1];
      assign nprio = cprio[i+1];
    end

    apq_cell #(
      .INDEX (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl[i]),
      .valid        (CNT_W'(i) < count),
      .load_id      (req_id),
      .load_prio    (load_prio),
      .nxt_id       (nid),
      .nxt_prio     (nprio),
      .match_id     (req_id),
      .match        (match[i]),
      .best_in      (best[i]),
      .best_idx_in  (best_idx[i]),
      .best_out     (best[i+1]),
      .best_idx_out (best_idx[i+1]),
      .win_idx      (best_idx[NUM_REQUESTERS]),
      .id           (cid[i]),
      .prio         (cprio[i])
    );
  end

`ifndef SYNTH
  // fill count stays within the row
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_REQUESTERS))
    else $error("queue count exceeds depth");

  // the pending requester id sits in at most one slot
  a_unique: assert property (@(posedge clk) disable iff (rst)
    $countones(match) <= 1)
    else $error("requester queued twice");

  // a grant removes exactly one entry
  a_serve_dec: assert property (@(posedge clk) disable iff (rst)
    serve_ok |=> count == $past(count) - CNT_W'(1))
    else $error("grant did not remove one entry");

  // an accepted enqueue adds exactly one entry
  a_enq_inc: assert property (@(posedge clk) disable iff (rst)
    enq_ok |=> count == $past(count) + CNT_W'(1))
    else $error("enqueue did not add one entry");

  // every executed item leaves a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> rsp.valid)
    else $error("executed item without result");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the aging priority request queue
// Drives enqueue and serve items with random gaps and result stalls, updates
// its own queue and priority model on every accepted item, and compares each
// result field by field. Runs several base priority settings, extremes too.
// ----------------------------------------------------------------------------
module tb;

  localparam int NUM_REQ        = apq_pkg::NUM_REQUESTERS_DEF;
  localparam int NUM_PHASES     = 7;
  localparam int RAND_PER_PHASE = 180;
  localparam int CYCLE_LIMIT    = 300000;
  localparam apq_pkg::base_t BASE_AT_RESET [apq_pkg::NUM_BASE_REGS] =
    '{3'd1, 3'd1, 3'd4, 3'd4, 3'd7, 3'd7};

  // one request item; hold marks a pause until all results are back
  typedef struct packed {
    logic         hold;
    logic         mode;
    apq_pkg::id_t id;
  } queue_op_t;

  typedef struct packed {
    apq_pkg::status_t            status;
    apq_pkg::id_t                granted_id;
    logic [apq_pkg::COUNT_W-1:0] count;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst;

  apq_req_if req_ch ();
  apq_rsp_if rsp_ch ();
  apq_cfg_if cfg_ch ();

  aging_priority_request_queue_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and bookkeeping
  queue_op_t     op_backlog [$];
  queue_result_t results_due [$];
  queue_op_t     next_op;
  int            send_gap;
  int            hold_gap;
  int            n_accepted;
  int            n_checked;
  int            n_errors;
  int            n_settings;
  int            cycles;
  int            status_seen [5];
  bit            src_gaps;
  bit            snk_stalls;

  // model state
  apq_pkg::id_t   waiting_ids [$];
  apq_pkg::prio_t cur_prio [NUM_REQ];
  apq_pkg::base_t base_copy [apq_pkg::NUM_BASE_REGS];

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // apply one item to the queue model and return the result it should give
  function automatic queue_result_t apply_queue_op(queue_op_t op);
    queue_result_t  r;
    int             win;
    apq_pkg::prio_t best;
    bit             dup;
    r = '{status: apq_pkg::ST_ENQUEUED, granted_id: apq_pkg::id_t'(0), count: '0};
    if (op.mode == apq_pkg::MODE_ENQ) begin
      dup = 1'b0;
      foreach (waiting_ids[i])
        if (waiting_ids[i] == op.id) dup = 1'b1;
      if (waiting_ids.size() >= NUM_REQ || op.id >= NUM_REQ) begin
        r.status = apq_pkg::ST_FULL;
      end else if (dup) begin
        r.status = apq_pkg::ST_DUP;
      end else begin
        waiting_ids.push_back(op.id);
        cur_prio[op.id] = apq_pkg::prio_t'(base_copy[op.id]);
        r.status = apq_pkg::ST_ENQUEUED;
      end
    end else if (waiting_ids.size() == 0) begin
      r.status = apq_pkg::ST_EMPTY;
    end else begin
      // lowest priority under the limit, earliest on ties; else the head
      win  = 0;
      best = apq_pkg::AGING_LIMIT;
      foreach (waiting_ids[i])
        if (cur_prio[waiting_ids[i]] < best) begin
          best = cur_prio[waiting_ids[i]];
          win  = i;
        end
      r.granted_id = waiting_ids[win];
      r.status     = apq_pkg::ST_GRANTED;
      waiting_ids.delete(win);
      // everyone left behind ages, floor saturates
      foreach (waiting_ids[i])
        if (cur_prio[waiting_ids[i]] != apq_pkg::PRIO_FLOOR)
          cur_prio[waiting_ids[i]] = cur_prio[waiting_ids[i]] - apq_pkg::prio_t'(1);
    end
    r.count = apq_pkg::COUNT_W'(waiting_ids.size());
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic add_op(input logic mode, input int id);
    op_backlog.push_back(queue_op_t'{1'b0, mode, apq_pkg::id_t'(id)});
  endtask

  // register writes, optionally also to the two unused indexes
  task automatic load_bases(input apq_pkg::base_t vals [apq_pkg::NUM_BASE_REGS],
                            input bit poke_unused);
    int last;
    last = poke_unused ? apq_pkg::NUM_BASE_REGS + 1 : apq_pkg::NUM_BASE_REGS - 1;
    @(posedge clk);
    for (int i = 0; i <= last; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= apq_pkg::CFG_IDX_W'(i);
      cfg_ch.wdata <= (i < apq_pkg::NUM_BASE_REGS) ? vals[i] : apq_pkg::base_t'($urandom);
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // nothing queued, nothing in flight, then a few spare cycles
  task automatic wait_until_idle();
    do @(negedge clk);
    while (op_backlog.size() != 0 || req_ch.valid || n_accepted != n_checked);
    repeat (3) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap     <= 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (send_gap != 0) begin
        req_ch.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (op_backlog.size() != 0 && op_backlog[0].hold) begin
        // hold off until every outstanding result has come back
        req_ch.valid <= 1'b0;
        if (!req_ch.valid && n_accepted == n_checked) void'(op_backlog.pop_front());
      end else if (op_backlog.size() != 0) begin
        next_op             = op_backlog.pop_front();
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= next_op.mode;
        req_ch.requester_id <= next_op.id;
        send_gap            <= src_gaps ? pick_gap() : 0;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_gap     <= 0;
    end else if (hold_gap != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_gap     <= hold_gap - 1;
    end else if (snk_stalls && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      hold_gap     <= pick_gap();
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // monitor: check results first, then predict newly accepted items
  always @(posedge clk) begin
    queue_result_t want;
    if (rst) begin
      waiting_ids.delete();
      base_copy = BASE_AT_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < apq_pkg::NUM_BASE_REGS)
        base_copy[cfg_ch.index] = cfg_ch.wdata;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (results_due.size() == 0) begin
          flag_mismatch("result with nothing outstanding");
        end else begin
          want = results_due.pop_front();
          if (rsp_ch.status !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", rsp_ch.status, want.status));
          if (rsp_ch.granted_id !== want.granted_id)
            flag_mismatch($sformatf("granted_id %0d, want %0d",
                                    rsp_ch.granted_id, want.granted_id));
          if (rsp_ch.queue_count !== want.count)
            flag_mismatch($sformatf("queue_count %0d, want %0d",
                                    rsp_ch.queue_count, want.count));
        end
        if (rsp_ch.status < 5) status_seen[rsp_ch.status]++;
        n_checked <= n_checked + 1;
      end
      if (req_ch.valid && req_ch.ready) begin
        results_due.push_back(apply_queue_op(
          queue_op_t'{1'b0, req_ch.mode, req_ch.requester_id}));
        n_accepted <= n_accepted + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    apq_pkg::base_t setting [apq_pkg::NUM_BASE_REGS];
    apq_pkg::id_t   shuffled [$];
    int             n_made;
    int             pick;
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.mode         = apq_pkg::MODE_ENQ;
    req_ch.requester_id = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.wdata        = '0;
    src_gaps            = 1'b1;
    snk_stalls          = 1'b1;
    n_accepted          = 0;
    n_checked           = 0;
    n_errors            = 0;
    n_settings          = 1;
    cycles              = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_until_idle();
      // base priority setting for this phase; the first keeps reset values
      if (ph == 1) begin
        setting = '{default: apq_pkg::base_t'(0)};
        load_bases(setting, 1'b0);
      end else if (ph == 2) begin
        setting = '{default: apq_pkg::base_t'(7)};
        load_bases(setting, 1'b1);
      end else if (ph > 2) begin
        foreach (setting[i]) setting[i] = apq_pkg::base_t'($urandom);
        load_bases(setting, ph[0]);
      end
      @(negedge clk);
      src_gaps   = (ph % 4 == 0) || (ph % 4 == 1);
      snk_stalls = (ph % 4 == 0) || (ph % 4 == 2);

      if (ph == 0) begin
        add_op(apq_pkg::MODE_SERVE, 0);         // serve on empty queue
        add_op(apq_pkg::MODE_ENQ, 4);
        add_op(apq_pkg::MODE_ENQ, 5);
        add_op(apq_pkg::MODE_SERVE, 7);         // nobody under the limit: head wins
        for (int i = 0; i < 4; i++) add_op(apq_pkg::MODE_ENQ, i);
        add_op(apq_pkg::MODE_ENQ, 4);           // queue now full
        add_op(apq_pkg::MODE_ENQ, 6);           // id out of range on full queue
        add_op(apq_pkg::MODE_ENQ, 1);           // full queue
        for (int i = 0; i < 6; i++) add_op(apq_pkg::MODE_SERVE, i);
        add_op(apq_pkg::MODE_ENQ, 7);           // id out of range, room left
        add_op(apq_pkg::MODE_ENQ, 3);
        add_op(apq_pkg::MODE_ENQ, 3);           // already queued
        add_op(apq_pkg::MODE_SERVE, 2);
        add_op(apq_pkg::MODE_SERVE, 5);         // empty again
      end

      // random part: mostly legal traffic, some bursts that enqueue every id and then serve four times
      n_made = 0;
      while (n_made < RAND_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (n_made >= RAND_PER_PHASE / 2 && n_made < RAND_PER_PHASE / 2 + 8 &&
            (op_backlog.size() == 0 || !op_backlog[$].hold))
          op_backlog.push_back(queue_op_t'{1'b1, apq_pkg::MODE_ENQ, apq_pkg::id_t'(0)});
        if (pick < 8) begin
          shuffled = '{apq_pkg::id_t'(0), apq_pkg::id_t'(1), apq_pkg::id_t'(2),
                       apq_pkg::id_t'(3), apq_pkg::id_t'(4), apq_pkg::id_t'(5)};
          shuffled.shuffle();
          foreach (shuffled[i]) add_op(apq_pkg::MODE_ENQ, shuffled[i]);
          for (int i = 0; i < 4; i++) add_op(apq_pkg::MODE_SERVE, $urandom_range(0, 7));
          n_made += 10;
        end else if (pick < 52) begin
          add_op(apq_pkg::MODE_ENQ, $urandom_range(0, 5));
          n_made++;
        end else if (pick < 57) begin
          add_op(apq_pkg::MODE_ENQ, $urandom_range(6, 7));
          n_made++;
        end else begin
          add_op(apq_pkg::MODE_SERVE, $urandom_range(0, 7));
          n_made++;
        end
      end
    end

    wait_until_idle();
    repeat (4) @(posedge clk);
    if (results_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", results_due.size()));

    $display("covered %0d requests over %0d base settings: %0d grants, %0d empty serves",
             n_accepted, n_settings, status_seen[apq_pkg::ST_GRANTED],
             status_seen[apq_pkg::ST_EMPTY]);
    $display("enqueued %0d, rejected %0d as full or bad id, %0d as already queued",
             status_seen[apq_pkg::ST_ENQUEUED], status_seen[apq_pkg::ST_FULL],
             status_seen[apq_pkg::ST_DUP]);
    if (n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/apq_pkg.sv
hdl/apq_req_if.sv
hdl/apq_rsp_if.sv
hdl/apq_cfg_if.sv
hdl/apq_cell.sv
hdl/aging_priority_request_queue_unit.sv
tb/tb.sv
